/* rtl/core/psq_pkg.sv */
`default_nettype none
package psq_pkg;

   localparam int SIZE_BITS = 24;
   localparam int HANDLE_W  = 16;

   typedef enum logic [2:0] {
      ST_QUEUED   = 3'd0,
      ST_LOWDROP  = 3'd1,
      ST_OVERDROP = 3'd2,
      ST_TOOLARGE = 3'd3,
      ST_OVERFLOW = 3'd4,
      ST_POPPED   = 3'd5,
      ST_EMPTY    = 3'd6
   } status_type;

   localparam logic [1:0] CSR_MAX_MSG   = 2'd0;
   localparam logic [1:0] CSR_MAX_LOW   = 2'd1;
   localparam logic [1:0] CSR_MAX_TOTAL = 2'd2;
   localparam logic [1:0] LOW_QUEUE     = 2'd3;

   typedef struct packed {
      logic                 kind;
      logic [1:0]           priority_req;
      logic [SIZE_BITS-1:0] msg_size;
      logic [HANDLE_W-1:0]  msg_handle;
      logic                 drop_if_overloaded;
   } req_type;

   typedef struct packed {
      logic [2:0]           status;
      logic [1:0]           queue_index;
      logic [HANDLE_W-1:0]  out_handle;
      logic [SIZE_BITS-1:0] out_size;
      logic [6:0]           evicted_count;
   } rsp_type;

   // classified command from the front end
   typedef struct packed {
      logic                 pop;
      logic                 too_large;
      logic [1:0]           queue;
      logic [SIZE_BITS-1:0] size;
      logic [HANDLE_W-1:0]  handle;
      logic                 drop;
   } cmd_type;

   function automatic logic [3:0] wrr_weight(input logic [1:0] q);
      case (q)
         2'd0:    wrr_weight = 4'd8;
         2'd1:    wrr_weight = 4'd4;
         2'd2:    wrr_weight = 4'd2;
         default: wrr_weight = 4'd1;
      endcase
   endfunction

endpackage
`default_nettype wire

/* rtl/core/psq_front.sv */
`default_nettype none
module psq_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire psq_pkg::req_type req_data,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [1:0]       csr_index,
   input  wire logic [31:0]      csr_data,
   output logic [31:0]           max_low,
   output logic [31:0]           max_total,
   output logic                  cmd_valid,
   input  wire logic             cmd_stall,
   output psq_pkg::cmd_type      cmd_data
);
   import psq_pkg::*;

   logic [31:0] max_msg_ff, max_low_ff, max_total_ff;
   logic        valid_ff;
   cmd_type     cmd_ff, cmd_in;

   assign csr_ready = 1'b1;
   assign max_low   = max_low_ff;
   assign max_total = max_total_ff;
   assign req_stall = valid_ff && cmd_stall;
   assign cmd_valid = valid_ff;
   assign cmd_data  = cmd_ff;

   always_comb begin
      cmd_in.pop       = req_data.kind;
      cmd_in.too_large = {8'd0, req_data.msg_size} > max_msg_ff;
      cmd_in.queue     = req_data.priority_req;
      cmd_in.size      = req_data.msg_size;
      cmd_in.handle    = req_data.msg_handle;
      cmd_in.drop      = req_data.drop_if_overloaded;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= 1'b0;
         max_msg_ff   <= 32'd1048576;
         max_low_ff   <= 32'd262144;
         max_total_ff <= 32'd4194304;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               CSR_MAX_MSG:   max_msg_ff   <= csr_data;
               CSR_MAX_LOW:   max_low_ff   <= csr_data;
               CSR_MAX_TOTAL: max_total_ff <= csr_data;
               default: ;
            endcase
         end
         if (!req_stall) begin
            valid_ff <= req_valid;
            if (req_valid) cmd_ff <= cmd_in;
         end
      end
   end
endmodule
`default_nettype wire

/* rtl/core/psq_back.sv */
`default_nettype none
module psq_back #(
   parameter int QUEUE_DEPTH = 64,
   parameter int HANDLE_BITS = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             cmd_valid,
   output logic                  cmd_stall,
   input  wire psq_pkg::cmd_type cmd_data,
   input  wire logic [31:0]      max_low,
   input  wire logic [31:0]      max_total,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output psq_pkg::rsp_type      rsp_data
);
   import psq_pkg::*;

   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int EW = SIZE_BITS + HANDLE_BITS;

   typedef enum logic [2:0] {
      S_IDLE, S_POPSCAN, S_READ, S_WAIT, S_LOWEV, S_TOTEV, S_FINAL, S_OUT
   } state_type;

   state_type          state_ff;
   cmd_type            cmd_ff;
   logic [EW-1:0]      mem [4][QUEUE_DEPTH];
   logic [EW-1:0]      rdata_ff;
   logic [PW-1:0]      head_ff [4];
   logic [CW-1:0]      count_ff [4];
   logic [3:0]         credit_ff [4];
   logic [1:0]         ptr_ff, scan_ff, sel_ff;
   logic [32:0]        total_ff, low_ff;
   logic [6:0]         ev_ff;
   logic               rd_pop_ff;
   rsp_type            work_ff;
   rsp_type            rsp_ff;
   logic               out_ff;

   logic [33:0]        low_need, tot_need;
   logic [PW:0]        tail_sum;
   logic [PW-1:0]      tail;
   logic [SIZE_BITS-1:0] rsize;
   logic [3:0]         cr;
   logic               out_fire;

   assign low_need  = {1'b0, low_ff} + {10'd0, cmd_ff.size};
   assign tot_need  = {1'b0, total_ff} + {10'd0, cmd_ff.size};
   assign tail_sum  = {1'b0, head_ff[cmd_ff.queue]} + (PW+1)'(count_ff[cmd_ff.queue]);
   assign tail      = (tail_sum >= (PW+1)'(QUEUE_DEPTH)) ?
                      PW'(tail_sum - (PW+1)'(QUEUE_DEPTH)) : PW'(tail_sum);
   assign rsize     = rdata_ff[EW-1 -: SIZE_BITS];
   assign cr        = (credit_ff[sel_ff] == 4'd0) ? wrr_weight(sel_ff) : credit_ff[sel_ff];
   assign cmd_stall = (state_ff != S_IDLE);
   assign out_fire  = (state_ff == S_OUT) && (!out_ff || !rsp_stall);
   assign rsp_valid = out_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         out_ff   <= 1'b0;
         ptr_ff   <= 2'd0;
         total_ff <= '0;
         low_ff   <= '0;
         for (int i = 0; i < 4; i++) begin
            head_ff[i]   <= '0;
            count_ff[i]  <= '0;
            credit_ff[i] <= '0;
         end
      end else begin
         if (out_fire) out_ff <= 1'b1;
         else if (!rsp_stall) out_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: if (cmd_valid) begin
               cmd_ff  <= cmd_data;
               ev_ff   <= '0;
               scan_ff <= ptr_ff;
               work_ff <= '0;
               if (cmd_data.pop) state_ff <= S_POPSCAN;
               else if (cmd_data.too_large) begin
                  work_ff.status <= ST_TOOLARGE;
                  state_ff       <= S_OUT;
               end else if (cmd_data.queue == LOW_QUEUE) state_ff <= S_LOWEV;
               else state_ff <= S_TOTEV;
            end
            S_POPSCAN: begin
               // visit one queue a cycle from the serve pointer
               if (count_ff[scan_ff] != '0) begin
                  sel_ff    <= scan_ff;
                  rd_pop_ff <= 1'b1;
                  state_ff  <= S_READ;
               end else if (scan_ff == ptr_ff - 2'd1) begin
                  for (int i = 0; i < 4; i++) credit_ff[i] <= wrr_weight(2'(i));
                  work_ff.status <= ST_EMPTY;
                  state_ff       <= S_OUT;
               end else scan_ff <= scan_ff + 2'd1;
            end
            S_READ: begin
               rdata_ff <= mem[sel_ff][head_ff[sel_ff]];
               state_ff <= S_WAIT;
            end
            S_WAIT: begin
               // retire the head entry that was read
               head_ff[sel_ff]  <= (head_ff[sel_ff] == PW'(QUEUE_DEPTH - 1)) ? '0 :
                                   head_ff[sel_ff] + PW'(1);
               count_ff[sel_ff] <= count_ff[sel_ff] - CW'(1);
               total_ff <= total_ff - {9'd0, rsize};
               if (sel_ff == LOW_QUEUE) low_ff <= low_ff - {9'd0, rsize};
               if (rd_pop_ff) begin
                  if (cr == 4'd1) begin
                     credit_ff[sel_ff] <= wrr_weight(sel_ff);
                     ptr_ff <= sel_ff + 2'd1;
                  end else begin
                     credit_ff[sel_ff] <= cr - 4'd1;
                     ptr_ff <= sel_ff;
                  end
                  work_ff.status      <= ST_POPPED;
                  work_ff.queue_index <= sel_ff;
                  work_ff.out_handle  <= HANDLE_W'(rdata_ff[HANDLE_BITS-1:0]);
                  work_ff.out_size    <= rsize;
                  state_ff <= S_OUT;
               end else begin
                  ev_ff    <= ev_ff + 7'd1;
                  state_ff <= (cmd_ff.queue == LOW_QUEUE && work_ff.status == ST_QUEUED
                               && low_need > {2'd0, max_low}) ? S_LOWEV : S_TOTEV;
               end
            end
            S_LOWEV: begin
               if (low_need <= {2'd0, max_low}) state_ff <= S_TOTEV;
               else if (count_ff[LOW_QUEUE] != '0) begin
                  sel_ff <= LOW_QUEUE; rd_pop_ff <= 1'b0; state_ff <= S_READ;
               end else begin
                  work_ff.status <= ST_LOWDROP;
                  state_ff       <= S_OUT;
               end
            end
            S_TOTEV: begin
               if (tot_need <= {2'd0, max_total}) state_ff <= S_FINAL;
               else if (count_ff[LOW_QUEUE] != '0) begin
                  sel_ff <= LOW_QUEUE; rd_pop_ff <= 1'b0; state_ff <= S_READ;
               end else begin
                  work_ff.status <= cmd_ff.drop ? ST_OVERDROP : ST_OVERFLOW;
                  state_ff       <= S_OUT;
               end
            end
            S_FINAL: begin
               if (count_ff[cmd_ff.queue] >= CW'(QUEUE_DEPTH))
                  work_ff.status <= cmd_ff.drop ? ST_OVERDROP : ST_OVERFLOW;
               else begin
                  mem[cmd_ff.queue][tail] <= {cmd_ff.size, HANDLE_BITS'(cmd_ff.handle)};
                  count_ff[cmd_ff.queue] <= count_ff[cmd_ff.queue] + CW'(1);
                  total_ff <= total_ff + {9'd0, cmd_ff.size};
                  if (cmd_ff.queue == LOW_QUEUE) low_ff <= low_ff + {9'd0, cmd_ff.size};
                  work_ff.status <= ST_QUEUED;
               end
               state_ff <= S_OUT;
            end
            S_OUT: if (out_fire) begin
               // hold the working result until the output register is free
               rsp_ff   <= {work_ff.status, work_ff.queue_index, work_ff.out_handle,
                            work_ff.out_size, ev_ff};
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

/* rtl/core/priority_send_queue_scheduler.sv */
`default_nettype none
// Flow: a pop scans the queues one queue a cycle from the serve pointer, then does a
// memory read, or answers empty when every queue is empty; an enqueue checks the low
// budget (low queue only) and the total budget, evicting low entries one by one.
// An oversize message goes straight to the output. Only one request is in the back
// end at a time; a one-entry front register takes the next request meanwhile.
// Reset: synchronous; queues empty, credits zero, budgets at their default values.
module priority_send_queue_scheduler #(
   parameter int QUEUE_DEPTH = 64,
   parameter int HANDLE_BITS = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire psq_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output psq_pkg::rsp_type      rsp_data,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [1:0]       csr_index,
   input  wire logic [31:0]      csr_data
);
   import psq_pkg::*;

   logic        cmd_valid, cmd_stall;
   cmd_type     cmd_data;
   logic [31:0] max_low, max_total;

   psq_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .csr_valid, .csr_ready, .csr_index, .csr_data,
      .max_low, .max_total, .cmd_valid, .cmd_stall, .cmd_data
   );

   psq_back #(.QUEUE_DEPTH(QUEUE_DEPTH), .HANDLE_BITS(HANDLE_BITS)) u_back (
      .clock, .reset, .cmd_valid, .cmd_stall, .cmd_data,
      .max_low, .max_total, .rsp_valid, .rsp_stall, .rsp_data
   );
endmodule
`default_nettype wire
